### src/gcl_pkg.sv
`timescale 1ns / 1ps
package gcl_pkg;
	localparam int MAX_STOPS_DEF = 7;
	localparam int POS_FRAC_DEF = 16;
	localparam int NUM_STOP_REGS = 7;
	localparam int REG_W = 41;
	localparam int STOP_POS_LSB = 24;
	localparam int STOP_POS_W = POS_FRAC_DEF + 1;
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_STOP_COUNT = 3'd0;
	localparam logic [7:0] WHITE = 8'd255;

	// classified job handed from front to back
	typedef struct packed {
		logic       interp;
		logic [7:0] cs_r;
		logic [7:0] cs_g;
		logic [7:0] cs_b;
		logic [7:0] ce_r;
		logic [7:0] ce_g;
		logic [7:0] ce_b;
		logic [STOP_POS_W-1:0] off;
		logic [STOP_POS_W-1:0] den;
	} job_t;
endpackage

### src/gradient_color_lookup.sv
`timescale 1ns / 1ps
// Gradient color lookup: position -> interpolated red, green, blue.
// End colors and white pass straight through. An interpolated segment runs,
// per channel, a multiply and then an 8-bit divide in the shared divider.
// Start is taken only while busy is low; busy is high while an item is at work.
// Reset (arst_n low, asynchronous) clears stop_count and stops; done drops.
// Results are shown for one cycle on done; the receiver cannot stall.
module gradient_color_lookup #(
	parameter int MAX_STOPS = gcl_pkg::MAX_STOPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [gcl_pkg::STOP_POS_W-1:0] position,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [gcl_pkg::REG_W-1:0] cfg_data,
	output logic done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	logic [2:0] count_q;
	logic [gcl_pkg::NUM_STOP_REGS-1:0][gcl_pkg::REG_W-1:0] stops_q;
	logic job_valid;
	gcl_pkg::job_t job;

	// register file: index 0 is the count, 1..7 the stops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stops_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == gcl_pkg::REG_STOP_COUNT) count_q <= cfg_data[2:0];
			else stops_q[cfg_index - 3'd1] <= cfg_data;
		end
	end

	// front: pick the bracketing segment, register the job
	gcl_front #(.MAX_STOPS(MAX_STOPS)) u_front (
		.clk(clk), .arst_n(arst_n), .go(start && !busy), .pos(position),
		.count(count_q), .stops(stops_q), .job_valid(job_valid), .job(job)
	);

	// back: interpolate the three channels
	gcl_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.busy(busy), .done(done), .red(red), .green(green), .blue(blue)
	);
endmodule

### src/gcl_front.sv
`timescale 1ns / 1ps
module gcl_front #(
	parameter int MAX_STOPS = gcl_pkg::MAX_STOPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [gcl_pkg::STOP_POS_W-1:0] pos,
	input  logic [2:0] count,
	input  logic [gcl_pkg::NUM_STOP_REGS-1:0][gcl_pkg::REG_W-1:0] stops,
	output logic job_valid,
	output gcl_pkg::job_t job
);
	logic [2:0] n;
	logic [2:0] s_idx;
	logic [2:0] k_idx;
	logic found;
	logic [gcl_pkg::STOP_POS_W-1:0] sp [gcl_pkg::NUM_STOP_REGS];
	gcl_pkg::job_t nxt;

	always_comb begin
		for (int i = 0; i < gcl_pkg::NUM_STOP_REGS; i++)
			sp[i] = stops[i][gcl_pkg::STOP_POS_LSB +: gcl_pkg::STOP_POS_W];
		n = (32'(count) > MAX_STOPS) ? 3'(MAX_STOPS) : count;
		found = 1'b0;
		s_idx = '0;
		for (int i = 1; i < gcl_pkg::NUM_STOP_REGS; i++) begin
			if (!found && 3'(i) < n && pos >= sp[i-1] && pos <= sp[i]) begin
				found = 1'b1;
				s_idx = 3'(i - 1);
			end
		end
		k_idx = (pos < sp[0]) ? 3'd0 : n - 3'd1;
		nxt = '0;
		if (n == 3'd0) begin
			nxt.cs_r = gcl_pkg::WHITE;
			nxt.cs_g = gcl_pkg::WHITE;
			nxt.cs_b = gcl_pkg::WHITE;
		end else if (!found) begin
			{nxt.cs_r, nxt.cs_g, nxt.cs_b} = stops[k_idx][23:0];
		end else begin
			{nxt.cs_r, nxt.cs_g, nxt.cs_b} = stops[s_idx][23:0];
			{nxt.ce_r, nxt.ce_g, nxt.ce_b} = stops[s_idx + 3'd1][23:0];
			nxt.off = gcl_pkg::STOP_POS_W'(pos - sp[s_idx]);
			nxt.den = gcl_pkg::STOP_POS_W'(sp[s_idx + 3'd1] - sp[s_idx]);
			nxt.interp = (sp[s_idx + 3'd1] != sp[s_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) job_valid <= 1'b0;
		else job_valid <= go;
	end

	always_ff @(posedge clk) begin
		if (go) job <= nxt;
	end
endmodule

### src/gcl_back.sv
`timescale 1ns / 1ps
module gcl_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  gcl_pkg::job_t job,
	output logic busy,
	output logic done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	localparam int W = gcl_pkg::STOP_POS_W;
	localparam int NW = W + 8;
	typedef enum logic [1:0] {IDLE, MUL, DIV} st_t;
	st_t st_q;
	gcl_pkg::job_t j_q;
	logic [1:0] ch_q;
	logic [NW-1:0] rem_q;
	logic [7:0] quo_q;
	logic [3:0] bit_q;
	logic neg_q;
	logic [7:0] cs, ce, mag;
	logic [NW:0] trial;

	always_comb begin
		unique case (ch_q)
			2'd0: begin cs = j_q.cs_r; ce = j_q.ce_r; end
			2'd1: begin cs = j_q.cs_g; ce = j_q.ce_g; end
			default: begin cs = j_q.cs_b; ce = j_q.ce_b; end
		endcase
		mag = (ce >= cs) ? ce - cs : cs - ce;
		trial = {1'b0, rem_q} - ({1'b0, NW'(j_q.den)} << bit_q);
	end

	assign busy = job_valid || st_q != IDLE;

	// per channel: off*|dc| then an 8-bit restoring divide (quotient < 256)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			done <= 1'b0;
			ch_q <= '0;
			j_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			neg_q <= 1'b0;
			red <= '0;
			green <= '0;
			blue <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				IDLE: if (job_valid) begin
					j_q <= job;
					ch_q <= '0;
					if (job.interp) st_q <= MUL;
					else begin
						red <= job.cs_r; green <= job.cs_g; blue <= job.cs_b;
						done <= 1'b1;
					end
				end
				MUL: begin
					rem_q <= NW'(j_q.off) * NW'(mag);
					neg_q <= ce < cs;
					quo_q <= '0;
					bit_q <= 4'd7;
					st_q <= DIV;
				end
				DIV: begin
					logic [7:0] q, res;
					q = quo_q;
					if (!trial[NW]) begin
						rem_q <= trial[NW-1:0];
						q[bit_q[2:0]] = 1'b1;
					end
					quo_q <= q;
					if (bit_q != 4'd0) bit_q <= bit_q - 4'd1;
					else begin
						// floor for negative: round magnitude up if remainder left
						if (neg_q)
							res = cs - q - 8'((!trial[NW] ? trial[NW-1:0] : rem_q) != '0);
						else res = cs + q;
						unique case (ch_q)
							2'd0: red <= res;
							2'd1: green <= res;
							default: blue <= res;
						endcase
						if (ch_q == 2'd2) begin
							done <= 1'b1;
							st_q <= IDLE;
						end else begin
							ch_q <= ch_q + 2'd1;
							st_q <= MUL;
						end
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule
